// ===== sv/stereo_compressor_gate_assert.svh =====
// assertion macros used by the checker file
`ifndef STEREO_COMPRESSOR_GATE_ASSERT_SVH
`define STEREO_COMPRESSOR_GATE_ASSERT_SVH

// property checked only while out of reset
`define SCG_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("%m: check failed");

// property checked on every edge, reset included
`define SCG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// ===== sv/scg_pkg.sv =====
package scg_pkg;

    // default parameter values
    localparam int SINE_STEPS_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // fixed-point constants
    localparam logic [24:0] ONE_Q24     = 25'd16777216;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          GAIN_W      = 25;
    localparam int          LVL_W       = 21;
    localparam int          SINE_W      = 17;

    // configuration port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COMP_THRESHOLD = 4'd0,
        REG_COMP_RATIO     = 4'd1,
        REG_COMP_ATTACK    = 4'd2,
        REG_COMP_RELEASE   = 4'd3,
        REG_GATE_THRESHOLD = 4'd4,
        REG_GATE_RATIO     = 4'd5,
        REG_GATE_SUSTAIN   = 4'd6,
        REG_GATE_RELEASE   = 4'd7
    } reg_idx_t;

    // register reset values
    localparam logic [23:0] RST_COMP_THRESHOLD = 24'd8388608;
    localparam logic [16:0] RST_COMP_RATIO     = 17'd49152;
    localparam logic [24:0] RST_COMP_ATTACK    = 25'd2863311;
    localparam logic [24:0] RST_COMP_RELEASE   = 25'd8189537;
    localparam logic [23:0] RST_GATE_THRESHOLD = 24'd0;
    localparam logic [16:0] RST_GATE_RATIO     = 17'd49152;
    localparam logic [20:0] RST_GATE_SUSTAIN   = 21'd522000;
    localparam logic [24:0] RST_GATE_RELEASE   = 25'd8189537;
    localparam logic [20:0] RST_GATE_LEVEL     = 21'd65536;

    // datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_LOAD,
        UOP_DIV_Q,
        UOP_MUL_G_ATK,
        UOP_SUB_PROD,
        UOP_MUL_Q_ATK,
        UOP_MUL_REL,
        UOP_ADD_CLAMP,
        UOP_LOAD_SUSTAIN,
        UOP_MUL_LVL,
        UOP_SUB_LVL,
        UOP_MUL_F,
        UOP_SET_F,
        UOP_MUL_XF,
        UOP_SET_Y,
        UOP_DIV_IDX,
        UOP_ROM_RD,
        UOP_MUL_H,
        UOP_SET_H,
        UOP_MUL_YH,
        UOP_SET_YH,
        UOP_OUT_LOAD
    } uop_t;

    // controller to datapath
    typedef struct packed {
        uop_t uop;
        logic ch;      // 0 left, 1 right
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic above_l;
        logic above_r;
        logic gate_open;
        logic gl_gt_gr;
        logic gr_gt_gl;
        logic shape;
        logic div_done;
        logic out_full;
    } status_t;

    // taylor series denominators (2k)(2k+1)
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int k);
        case (k)
            1:       return term / 64'd6;
            2:       return term / 64'd20;
            3:       return term / 64'd42;
            4:       return term / 64'd72;
            5:       return term / 64'd110;
            6:       return term / 64'd156;
            7:       return term / 64'd210;
            default: return term;
        endcase
    endfunction

    // sine of a Q2.30 angle as Q1.16, used to build the table at elaboration
    function automatic logic [16:0] sine_q16(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        for (int k = 1; k <= 7; k++) begin
            term = (term * a2) >> 30;
            term = taylor_div(term, k);
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (unsigned'(sum) + 64'd8192) >> 14;
        if (r > 64'(ONE_Q16)) begin
            r = 64'(ONE_Q16);
        end
        return r[16:0];
    endfunction

endpackage

// ===== sv/scg_div.sv =====
module scg_div #(
    parameter int DVW  = 25,
    parameter int NUMW = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DVW-1:0]                rem_init,
    input  logic [NUMW-1:0]               num_init,
    input  logic [DVW-1:0]                divisor,
    input  logic [$clog2(NUMW+1)-1:0]     iters,
    output logic                          done,
    output logic [NUMW-1:0]               quo
);

    localparam int CNTW = $clog2(NUMW+1);

    logic [DVW-1:0]  rem_reg;
    logic [NUMW-1:0] num_reg;
    logic [NUMW-1:0] quo_reg;
    logic [DVW-1:0]  d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DVW:0]    rem2;
    logic            ge;
    logic [DVW:0]    diff;

    // one restoring step per cycle
    always_comb begin
        rem2 = {rem_reg, num_reg[NUMW-1]};
        ge   = rem2 >= {1'b0, d_reg};
        diff = rem2 - {1'b0, d_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= iters;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload of the divider
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            num_reg <= num_init;
            d_reg   <= divisor;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= ge ? diff[DVW-1:0] : rem2[DVW-1:0];
            num_reg <= {num_reg[NUMW-2:0], 1'b0};
            quo_reg <= {quo_reg[NUMW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/scg_datapath.sv =====
module scg_datapath #(
    parameter int SINE_STEPS  = scg_pkg::SINE_STEPS_DEF,
    parameter int SAMPLE_BITS = scg_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scg_pkg::cmd_t                   cmd,
    output scg_pkg::status_t                status,
    input  logic [DATA_W-1:0]               s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [DATA_W-1:0]               m_tdata,
    input  logic                            cfg_we,
    input  logic [scg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [scg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CW     = (SB > 24) ? SB : 24;
    localparam int AW     = CW + 2;
    localparam int BW     = 26;
    localparam int PW     = AW + BW;
    localparam int DVW    = CW + 1;
    localparam int IW     = $clog2(SINE_STEPS);
    localparam int NUMW   = 24;
    localparam int CNTW   = $clog2(NUMW+1);
    localparam int IDX_SH = 34;

    // reciprocal of the table step, exact for every level below pi/2
    localparam logic [63:0] IDX_RECIP_FULL =
        ((64'd1 << IDX_SH) * 64'(SINE_STEPS) + 64'(scg_pkg::HALF_PI_Q16) - 64'd1)
        / 64'(scg_pkg::HALF_PI_Q16);
    localparam logic [31:0] IDX_RECIP = IDX_RECIP_FULL[31:0];

    typedef logic [16:0] rom_t [SINE_STEPS];

    // quarter sine table built at elaboration
    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < SINE_STEPS; i++) begin
            t[i] = scg_pkg::sine_q16((64'(i) * scg_pkg::HALF_PI_Q30) / SINE_STEPS);
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [23:0] comp_thr_reg;
    logic [16:0] comp_ratio_reg;
    logic [24:0] comp_atk_reg;
    logic [24:0] comp_rel_reg;
    logic [23:0] gate_thr_reg;
    logic [16:0] gate_ratio_reg;
    logic [20:0] gate_sus_reg;
    logic [24:0] gate_rel_reg;

    // working state
    logic signed [SB-1:0] xl_reg, xr_reg;
    logic [SB-1:0]        ml_reg, mr_reg;
    logic [24:0]          gl_reg, gr_reg;
    logic [20:0]          lvl_reg;
    logic [24:0]          f_reg;
    logic [16:0]          h_reg;
    logic [16:0]          rom_reg;
    logic [IW-1:0]        idx_reg;
    logic signed [SB:0]   yl_reg, yr_reg;
    logic signed [PW-1:0] prod_reg;
    logic                 m_valid_reg;
    logic [SB-1:0]        ol_reg, or_reg;

    logic signed [SB-1:0] in_l, in_r;
    logic [SB-1:0]        in_ml, in_mr;
    logic [16:0]          cr, gr;
    logic [24:0]          g_cur;
    logic signed [SB-1:0] x_cur;
    logic signed [SB:0]   y_cur;
    logic [SB-1:0]        m_cur;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic [24:0]          prod_hi;
    logic [25:0]          g_sum;
    logic [24:0]          g_wb;
    logic                 g_we;
    logic signed [SB:0]   y_wb;
    logic                 y_we;
    logic                 div_start;
    logic [DVW-1:0]       div_rem;
    logic [NUMW-1:0]      div_num;
    logic [DVW-1:0]       div_d;
    logic [CNTW-1:0]      div_iters;
    logic                 div_done;
    logic [NUMW-1:0]      div_quo;
    logic [48:0]          idx_prod;

    // magnitude of a signed sample
    function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] x);
        logic signed [SB:0] xe;
        xe = (SB+1)'(x);
        return xe[SB] ? SB'(-xe) : SB'(xe);
    endfunction

    // saturate to the signed sample range
    function automatic logic [SB-1:0] sat(input logic signed [SB:0] y);
        if (y[SB] != y[SB-1]) begin
            return y[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        return y[SB-1:0];
    endfunction

    always_comb begin
        in_l  = s_tdata[SB-1:0];
        in_r  = s_tdata[2*SB-1:SB];
        in_ml = mag(in_l);
        in_mr = mag(in_r);
        cr    = (comp_ratio_reg > scg_pkg::ONE_Q16) ? scg_pkg::ONE_Q16 : comp_ratio_reg;
        gr    = (gate_ratio_reg > scg_pkg::ONE_Q16) ? scg_pkg::ONE_Q16 : gate_ratio_reg;
        g_cur = cmd.ch ? gr_reg : gl_reg;
        x_cur = cmd.ch ? xr_reg : xl_reg;
        y_cur = cmd.ch ? yr_reg : yl_reg;
        m_cur = cmd.ch ? mr_reg : ml_reg;
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.uop)
            scg_pkg::UOP_MUL_G_ATK: begin
                mul_a = signed'(AW'(g_cur));
                mul_b = signed'(BW'(comp_atk_reg));
            end
            scg_pkg::UOP_MUL_Q_ATK: begin
                mul_a = signed'(AW'(div_quo[23:0]));
                mul_b = signed'(BW'(comp_atk_reg));
            end
            scg_pkg::UOP_MUL_REL: begin
                mul_a = signed'(AW'(scg_pkg::ONE_Q24 - g_cur));
                mul_b = signed'(BW'(comp_rel_reg));
            end
            scg_pkg::UOP_MUL_LVL: begin
                mul_a = signed'(AW'(lvl_reg));
                mul_b = signed'(BW'(gate_rel_reg));
            end
            scg_pkg::UOP_MUL_F: begin
                mul_a = signed'(AW'(cr));
                mul_b = signed'(BW'(scg_pkg::ONE_Q24 - g_cur));
            end
            scg_pkg::UOP_MUL_XF: begin
                mul_a = AW'(x_cur);
                mul_b = signed'(BW'(f_reg));
            end
            scg_pkg::UOP_MUL_H: begin
                mul_a = signed'(AW'(gr));
                mul_b = signed'(BW'(scg_pkg::ONE_Q16 - rom_reg));
            end
            scg_pkg::UOP_MUL_YH: begin
                mul_a = AW'(y_cur);
                mul_b = signed'(BW'(h_reg));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // gain and sample write-back
    always_comb begin
        prod_hi = prod_reg[32 +: 25];
        g_sum   = {1'b0, g_cur} + {1'b0, prod_hi};
        g_wb    = g_cur;
        g_we    = 1'b0;
        y_wb    = y_cur;
        y_we    = 1'b0;
        case (cmd.uop)
            scg_pkg::UOP_SUB_PROD: begin
                g_wb = g_cur - prod_hi;
                g_we = 1'b1;
            end
            scg_pkg::UOP_ADD_CLAMP: begin
                g_wb = (g_sum > 26'(scg_pkg::ONE_Q24)) ? scg_pkg::ONE_Q24 : g_sum[24:0];
                g_we = 1'b1;
            end
            scg_pkg::UOP_SET_Y: begin
                y_wb = prod_reg[24 +: SB+1];
                y_we = 1'b1;
            end
            scg_pkg::UOP_SET_YH: begin
                y_wb = prod_reg[16 +: SB+1];
                y_we = 1'b1;
            end
            default: begin
                g_we = 1'b0;
                y_we = 1'b0;
            end
        endcase
    end

    // divider setup for threshold over magnitude, table index by reciprocal
    always_comb begin
        idx_prod  = 49'(lvl_reg[16:0]) * 49'(IDX_RECIP);
        div_start = (cmd.uop == scg_pkg::UOP_DIV_Q);
        div_rem   = DVW'(comp_thr_reg);
        div_num   = '0;
        div_d     = DVW'(m_cur);
        div_iters = CNTW'(NUMW);
    end

    scg_div #(
        .DVW  (DVW),
        .NUMW (NUMW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .num_init (div_num),
        .divisor  (div_d),
        .iters    (div_iters),
        .done     (div_done),
        .quo      (div_quo)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_thr_reg   <= scg_pkg::RST_COMP_THRESHOLD;
            comp_ratio_reg <= scg_pkg::RST_COMP_RATIO;
            comp_atk_reg   <= scg_pkg::RST_COMP_ATTACK;
            comp_rel_reg   <= scg_pkg::RST_COMP_RELEASE;
            gate_thr_reg   <= scg_pkg::RST_GATE_THRESHOLD;
            gate_ratio_reg <= scg_pkg::RST_GATE_RATIO;
            gate_sus_reg   <= scg_pkg::RST_GATE_SUSTAIN;
            gate_rel_reg   <= scg_pkg::RST_GATE_RELEASE;
        end else if (cfg_we) begin
            case (cfg_addr)
                scg_pkg::REG_COMP_THRESHOLD: comp_thr_reg   <= cfg_data[23:0];
                scg_pkg::REG_COMP_RATIO:     comp_ratio_reg <= cfg_data[16:0];
                scg_pkg::REG_COMP_ATTACK:    comp_atk_reg   <= cfg_data[24:0];
                scg_pkg::REG_COMP_RELEASE:   comp_rel_reg   <= cfg_data[24:0];
                scg_pkg::REG_GATE_THRESHOLD: gate_thr_reg   <= cfg_data[23:0];
                scg_pkg::REG_GATE_RATIO:     gate_ratio_reg <= cfg_data[16:0];
                scg_pkg::REG_GATE_SUSTAIN:   gate_sus_reg   <= cfg_data[20:0];
                scg_pkg::REG_GATE_RELEASE:   gate_rel_reg   <= cfg_data[24:0];
                default: begin
                end
            endcase
        end
    end

    // gains, gate level and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gl_reg      <= scg_pkg::ONE_Q24;
            gr_reg      <= scg_pkg::ONE_Q24;
            lvl_reg     <= scg_pkg::RST_GATE_LEVEL;
            m_valid_reg <= 1'b0;
        end else begin
            if (g_we && !cmd.ch) begin
                gl_reg <= g_wb;
            end
            if (g_we && cmd.ch) begin
                gr_reg <= g_wb;
            end
            if (cmd.uop == scg_pkg::UOP_LOAD_SUSTAIN) begin
                lvl_reg <= gate_sus_reg;
            end else if (cmd.uop == scg_pkg::UOP_SUB_LVL) begin
                lvl_reg <= lvl_reg - prod_reg[32 +: 21];
            end
            if (cmd.uop == scg_pkg::UOP_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        if (cmd.uop == scg_pkg::UOP_LOAD) begin
            xl_reg <= in_l;
            xr_reg <= in_r;
            ml_reg <= in_ml;
            mr_reg <= in_mr;
        end
        if (cmd.uop == scg_pkg::UOP_SET_F) begin
            f_reg <= scg_pkg::ONE_Q24 - prod_reg[16 +: 25];
        end
        if (cmd.uop == scg_pkg::UOP_SET_H) begin
            h_reg <= scg_pkg::ONE_Q16 - prod_reg[16 +: 17];
        end
        if (cmd.uop == scg_pkg::UOP_DIV_IDX) begin
            idx_reg <= idx_prod[IDX_SH +: IW];
        end
        if (cmd.uop == scg_pkg::UOP_ROM_RD) begin
            rom_reg <= SINE_ROM[idx_reg];
        end
        if (y_we && !cmd.ch) begin
            yl_reg <= y_wb;
        end
        if (y_we && cmd.ch) begin
            yr_reg <= y_wb;
        end
        if (cmd.uop == scg_pkg::UOP_OUT_LOAD) begin
            ol_reg <= sat(yl_reg);
            or_reg <= sat(yr_reg);
        end
    end

    // status back to the controller
    always_comb begin
        status.above_l   = CW'(ml_reg) > CW'(comp_thr_reg);
        status.above_r   = CW'(mr_reg) > CW'(comp_thr_reg);
        status.gate_open = (CW'(ml_reg) > CW'(gate_thr_reg))
                        || (CW'(mr_reg) > CW'(gate_thr_reg));
        status.gl_gt_gr  = gl_reg > gr_reg;
        status.gr_gt_gl  = gr_reg > gl_reg;
        status.shape     = 21'(scg_pkg::HALF_PI_Q16) > lvl_reg;
        status.div_done  = div_done;
        status.out_full  = m_valid_reg && !m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'({or_reg, ol_reg});

endmodule

// ===== sv/scg_ctrl.sv =====
module scg_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output scg_pkg::cmd_t    cmd,
    input  scg_pkg::status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COMP_CHK,
        ST_DIV_WAIT,
        ST_ATK_MUL1,
        ST_ATK_SUB,
        ST_ATK_MUL2,
        ST_ADD_CLAMP,
        ST_XL_CHK,
        ST_XL_SUB,
        ST_XR_CHK,
        ST_XR_SUB,
        ST_GATE,
        ST_GATE_SUB,
        ST_FAC_MUL,
        ST_FAC_SET,
        ST_Y_MUL,
        ST_Y_SET,
        ST_SHAPE_CHK,
        ST_ROM_RD,
        ST_H_MUL,
        ST_H_SET,
        ST_YH_MUL,
        ST_YH_SET,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   ch_reg;
    logic   above;

    assign above = ch_reg ? status.above_r : status.above_l;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    ch_reg <= 1'b0;
                    if (s_tvalid) begin
                        state_reg <= ST_COMP_CHK;
                    end
                end
                ST_COMP_CHK:  state_reg <= above ? ST_DIV_WAIT : ST_ADD_CLAMP;
                ST_DIV_WAIT: begin
                    if (status.div_done) begin
                        state_reg <= ST_ATK_MUL1;
                    end
                end
                ST_ATK_MUL1:  state_reg <= ST_ATK_SUB;
                ST_ATK_SUB:   state_reg <= ST_ATK_MUL2;
                ST_ATK_MUL2:  state_reg <= ST_ADD_CLAMP;
                ST_ADD_CLAMP: begin
                    ch_reg    <= 1'b1;
                    state_reg <= ch_reg ? ST_XL_CHK : ST_COMP_CHK;
                end
                ST_XL_CHK:    state_reg <= status.gl_gt_gr ? ST_XL_SUB : ST_XR_CHK;
                ST_XL_SUB:    state_reg <= ST_XR_CHK;
                ST_XR_CHK:    state_reg <= status.gr_gt_gl ? ST_XR_SUB : ST_GATE;
                ST_XR_SUB:    state_reg <= ST_GATE;
                ST_GATE: begin
                    ch_reg    <= 1'b0;
                    state_reg <= status.gate_open ? ST_FAC_MUL : ST_GATE_SUB;
                end
                ST_GATE_SUB:  state_reg <= ST_FAC_MUL;
                ST_FAC_MUL:   state_reg <= ST_FAC_SET;
                ST_FAC_SET:   state_reg <= ST_Y_MUL;
                ST_Y_MUL:     state_reg <= ST_Y_SET;
                ST_Y_SET: begin
                    ch_reg    <= 1'b1;
                    state_reg <= ch_reg ? ST_SHAPE_CHK : ST_FAC_MUL;
                end
                ST_SHAPE_CHK: state_reg <= status.shape ? ST_ROM_RD : ST_OUT;
                ST_ROM_RD:    state_reg <= ST_H_MUL;
                ST_H_MUL:     state_reg <= ST_H_SET;
                ST_H_SET: begin
                    ch_reg    <= 1'b0;
                    state_reg <= ST_YH_MUL;
                end
                ST_YH_MUL:    state_reg <= ST_YH_SET;
                ST_YH_SET: begin
                    ch_reg    <= 1'b1;
                    state_reg <= ch_reg ? ST_OUT : ST_YH_MUL;
                end
                ST_OUT: begin
                    if (!status.out_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        cmd.uop = scg_pkg::UOP_NOP;
        cmd.ch  = ch_reg;
        case (state_reg)
            ST_IDLE:      cmd.uop = s_tvalid ? scg_pkg::UOP_LOAD : scg_pkg::UOP_NOP;
            ST_COMP_CHK:  cmd.uop = above ? scg_pkg::UOP_DIV_Q : scg_pkg::UOP_MUL_REL;
            ST_ATK_MUL1:  cmd.uop = scg_pkg::UOP_MUL_G_ATK;
            ST_ATK_SUB:   cmd.uop = scg_pkg::UOP_SUB_PROD;
            ST_ATK_MUL2:  cmd.uop = scg_pkg::UOP_MUL_Q_ATK;
            ST_ADD_CLAMP: cmd.uop = scg_pkg::UOP_ADD_CLAMP;
            ST_XL_CHK: begin
                cmd.ch  = 1'b0;
                cmd.uop = status.gl_gt_gr ? scg_pkg::UOP_MUL_G_ATK : scg_pkg::UOP_NOP;
            end
            ST_XL_SUB: begin
                cmd.ch  = 1'b0;
                cmd.uop = scg_pkg::UOP_SUB_PROD;
            end
            ST_XR_CHK: begin
                cmd.ch  = 1'b1;
                cmd.uop = status.gr_gt_gl ? scg_pkg::UOP_MUL_G_ATK : scg_pkg::UOP_NOP;
            end
            ST_XR_SUB: begin
                cmd.ch  = 1'b1;
                cmd.uop = scg_pkg::UOP_SUB_PROD;
            end
            ST_GATE:      cmd.uop = status.gate_open ? scg_pkg::UOP_LOAD_SUSTAIN
                                                     : scg_pkg::UOP_MUL_LVL;
            ST_GATE_SUB:  cmd.uop = scg_pkg::UOP_SUB_LVL;
            ST_FAC_MUL:   cmd.uop = scg_pkg::UOP_MUL_F;
            ST_FAC_SET:   cmd.uop = scg_pkg::UOP_SET_F;
            ST_Y_MUL:     cmd.uop = scg_pkg::UOP_MUL_XF;
            ST_Y_SET:     cmd.uop = scg_pkg::UOP_SET_Y;
            ST_SHAPE_CHK: cmd.uop = status.shape ? scg_pkg::UOP_DIV_IDX : scg_pkg::UOP_NOP;
            ST_ROM_RD:    cmd.uop = scg_pkg::UOP_ROM_RD;
            ST_H_MUL:     cmd.uop = scg_pkg::UOP_MUL_H;
            ST_H_SET:     cmd.uop = scg_pkg::UOP_SET_H;
            ST_YH_MUL:    cmd.uop = scg_pkg::UOP_MUL_YH;
            ST_YH_SET:    cmd.uop = scg_pkg::UOP_SET_YH;
            ST_OUT:       cmd.uop = status.out_full ? scg_pkg::UOP_NOP
                                                    : scg_pkg::UOP_OUT_LOAD;
            default:      cmd.uop = scg_pkg::UOP_NOP;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ===== sv/stereo_compressor_gate.sv =====
// Stereo compressor and noise gate.
// Input channel s_*: one stereo word per item, left sample in the low
// SAMPLE_BITS of s_tdata, right sample above it. Output channel m_*: one
// processed stereo word per item in the same layout, saturated.
// Configuration channel cfg_*: cfg_addr selects one of eight registers,
// cfg_data carries the value; indexes past the list are ignored. cfg_ready
// is always high; write only while no item is in flight.
// Items are handled one at a time by a controller that steps a datapath
// with one shared multiplier and one bit-serial divider. m_tvalid rises
// once the last step of the item stores the result. The shortest path has
// no channel above the compressor threshold, no cross-link step, gate open
// and no shaping; the longest runs every optional step, and each threshold
// division keeps the controller in its wait state until the divider is done.
// The next word can be taken in the cycle after the result is stored.
// After reset all gains are unity, the gate level is one radian-unit,
// registers hold their reset values and no output is pending.
// The result sits in an output register; the next item is taken while it
// waits, and only the final store of the following item stalls until
// m_tready frees the register.
module stereo_compressor_gate #(
    parameter int SINE_STEPS  = scg_pkg::SINE_STEPS_DEF,
    parameter int SAMPLE_BITS = scg_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((2*SAMPLE_BITS+7)/8)*8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [DATA_W-1:0]               s_tdata,   // left_in, right_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [DATA_W-1:0]               m_tdata,   // left_out, right_out
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [scg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    scg_pkg::cmd_t    cmd;
    scg_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    scg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // arithmetic and state
    scg_datapath #(
        .SINE_STEPS  (SINE_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .DATA_W      (DATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

endmodule

// ===== sv/scg_checker.sv =====
`include "stereo_compressor_gate_assert.svh"

module scg_checker #(
    parameter int DATA_W = 48
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    logic [1:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // words taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else if (in_acc && !out_acc) begin
            pend_reg <= pend_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    `SCG_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `SCG_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)
    `SCG_ASSERT(a_one_at_a_time, aclk, aresetn, in_acc |=> !s_tready)
    `SCG_ASSERT(a_no_invented, aclk, aresetn, m_tvalid |-> pend_reg != 2'd0)
    `SCG_ASSERT(a_bounded, aclk, aresetn, pend_reg != 2'd3)

endmodule

bind stereo_compressor_gate scg_checker #(
    .DATA_W (DATA_W)
) u_scg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
